FILE: design/stt_pkg.sv
// shared types, constants and tables of the source text tokenizer
`timescale 1ns / 1ps

package stt_pkg;

	localparam int POS_BITS   = 24;
	localparam int FIELD_BITS = 24;
	localparam int CH_BITS    = 8;
	localparam int KIND_BITS  = 5;
	localparam int KW_COUNT   = 6;
	localparam int WL_BITS    = 3;
	localparam int Q_DEPTH    = 4;
	localparam int Q_PTR_BITS = $clog2(Q_DEPTH);
	localparam int Q_CNT_BITS = $clog2(Q_DEPTH + 1);

	typedef logic [POS_BITS-1:0]   pos_t;
	typedef logic [FIELD_BITS-1:0] field_t;
	typedef logic [CH_BITS-1:0]    char_t;
	typedef logic [WL_BITS-1:0]    wlen_t;
	typedef logic [KW_COUNT-1:0]   kw_mask_t;

	localparam wlen_t    WL_MAX = '1;
	localparam kw_mask_t KW_ALL = '1;

	typedef enum logic [3:0] {
		MODE_IDLE,
		MODE_IDENT,
		MODE_INT,
		MODE_FRAC,
		MODE_STRING,
		MODE_COMMENT,
		MODE_OP_EQ,
		MODE_OP_BANG,
		MODE_OP_LT,
		MODE_OP_GT
	} scan_mode_t;

	typedef enum logic [KIND_BITS-1:0] {
		TK_EOF, TK_INT, TK_FLOAT, TK_STRING, TK_IDENT,
		TK_DEF, TK_RETURN, TK_IF, TK_ELSE, TK_WHILE, TK_PRINT,
		TK_PLUS, TK_MINUS, TK_STAR, TK_SLASH, TK_ASSIGN, TK_EQ, TK_NE,
		TK_LT, TK_GT, TK_LE, TK_GE, TK_LPAREN, TK_RPAREN, TK_COLON,
		TK_COMMA, TK_SEMI, TK_NEWLINE
	} token_kind_t;

	// source characters with a role of their own
	localparam char_t CH_NL     = 8'h0a;
	localparam char_t CH_QUOTE  = 8'h22;
	localparam char_t CH_HASH   = 8'h23;
	localparam char_t CH_DOT    = 8'h2e;
	localparam char_t CH_EQUAL  = 8'h3d;
	localparam char_t CH_BANG   = 8'h21;
	localparam char_t CH_LESS   = 8'h3c;
	localparam char_t CH_MORE   = 8'h3e;
	localparam char_t CH_PLUS   = 8'h2b;
	localparam char_t CH_MINUS  = 8'h2d;
	localparam char_t CH_STAR   = 8'h2a;
	localparam char_t CH_SLASH  = 8'h2f;
	localparam char_t CH_LPAREN = 8'h28;
	localparam char_t CH_RPAREN = 8'h29;
	localparam char_t CH_COLON  = 8'h3a;
	localparam char_t CH_COMMA  = 8'h2c;
	localparam char_t CH_SEMI   = 8'h3b;

	// keyword text, zero padded to eight characters
	localparam char_t KW_TEXT [KW_COUNT][8] = '{
		'{"d", "e", "f", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{"r", "e", "t", "u", "r", "n", 8'h00, 8'h00},
		'{"i", "f", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{"e", "l", "s", "e", 8'h00, 8'h00, 8'h00, 8'h00},
		'{"w", "h", "i", "l", "e", 8'h00, 8'h00, 8'h00},
		'{"p", "r", "i", "n", "t", 8'h00, 8'h00, 8'h00}
	};

	localparam wlen_t KW_LEN [KW_COUNT] = '{3'd3, 3'd6, 3'd2, 3'd4, 3'd5, 3'd5};

	localparam token_kind_t KW_KIND [KW_COUNT] = '{
		TK_DEF, TK_RETURN, TK_IF, TK_ELSE, TK_WHILE, TK_PRINT
	};

	typedef struct packed {
		token_kind_t kind;
		field_t      start;
		field_t      length;
		field_t      line;
		field_t      column;
		logic        last;
	} token_t;

	// tokens caused by one item, packed from the first slot
	typedef struct packed {
		logic [1:0] count;
		token_t     first;
		token_t     second;
	} token_pair_t;

endpackage

FILE: design/stt_scan.sv
// scanner state and the per-byte step that yields up to two tokens
`timescale 1ns / 1ps

module stt_scan (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  stt_pkg::char_t      ch,
	input  logic                eos,
	output stt_pkg::token_pair_t pair
);
	import stt_pkg::*;

	scan_mode_t mode_q, mode_d;
	pos_t       pos_q, pos_d;
	pos_t       line_q, line_d;
	pos_t       col_q, col_d;
	pos_t       start_q, start_d;
	kw_mask_t   cand_q, cand_d;
	wlen_t      wl_q, wl_d;

	pos_t     pos_c, line_c, col_c;
	logic     ch_letter, ch_numeral;
	kw_mask_t cand_m, cand_i;
	wlen_t    wl_m;

	logic        flush_has;
	token_t      flush_tok;
	token_kind_t ident_kind;

	logic   a_v, b_v, c_v;
	token_t tok_b, tok_c;

	// counters after taking the current byte, saturating
	always_comb begin
		pos_c  = (pos_q != '1) ? pos_q + POS_BITS'(1) : pos_q;
		line_c = line_q;
		col_c  = col_q;
		if (ch == CH_NL) begin
			line_c = (line_q != '1) ? line_q + POS_BITS'(1) : line_q;
			col_c  = POS_BITS'(1);
		end else if (col_q != '1) begin
			col_c = col_q + POS_BITS'(1);
		end
	end

	assign ch_letter  = (ch >= "a" && ch <= "z") || (ch >= "A" && ch <= "Z") || ch == "_";
	assign ch_numeral = ch >= "0" && ch <= "9";

	// keyword candidates narrowed by one character
	always_comb begin
		for (int k = 0; k < KW_COUNT; k++) begin
			cand_m[k] = cand_q[k] && (wl_q < KW_LEN[k]) && (KW_TEXT[k][wl_q] == ch);
			cand_i[k] = KW_TEXT[k][0] == ch;
		end
		wl_m = (wl_q != WL_MAX) ? wl_q + WL_BITS'(1) : wl_q;
	end

	always_comb begin
		ident_kind = TK_IDENT;
		for (int k = 0; k < KW_COUNT; k++) begin
			if (cand_q[k] && KW_LEN[k] == wl_q) begin
				ident_kind = KW_KIND[k];
			end
		end
	end

	// token still open before this byte
	always_comb begin
		flush_has        = 1'b1;
		flush_tok.kind   = TK_EOF;
		flush_tok.start  = '0;
		flush_tok.length = '0;
		flush_tok.line   = FIELD_BITS'(line_q);
		flush_tok.column = FIELD_BITS'(col_q);
		flush_tok.last   = 1'b0;
		unique case (mode_q)
			MODE_IDENT: begin
				flush_tok.kind = ident_kind;
				if (ident_kind == TK_IDENT) begin
					flush_tok.start  = FIELD_BITS'(start_q);
					flush_tok.length = FIELD_BITS'(pos_q - start_q);
				end
			end
			MODE_INT, MODE_FRAC: begin
				flush_tok.kind   = (mode_q == MODE_INT) ? TK_INT : TK_FLOAT;
				flush_tok.start  = FIELD_BITS'(start_q);
				flush_tok.length = FIELD_BITS'(pos_q - start_q);
			end
			MODE_OP_EQ: flush_tok.kind = TK_ASSIGN;
			MODE_OP_LT: flush_tok.kind = TK_LT;
			MODE_OP_GT: flush_tok.kind = TK_GT;
			default:    flush_has = 1'b0;
		endcase
	end

	always_comb begin
		logic cont;
		mode_d  = mode_q;
		pos_d   = pos_q;
		line_d  = line_q;
		col_d   = col_q;
		start_d = start_q;
		cand_d  = cand_q;
		wl_d    = wl_q;
		a_v     = 1'b0;
		b_v     = 1'b0;
		c_v     = 1'b0;
		cont    = 1'b0;
		tok_b.kind   = TK_EOF;
		tok_b.start  = '0;
		tok_b.length = '0;
		tok_b.line   = FIELD_BITS'(line_c);
		tok_b.column = FIELD_BITS'(col_c);
		tok_b.last   = 1'b1;
		tok_c.kind   = TK_STRING;
		tok_c.start  = '0;
		tok_c.length = '0;
		tok_c.line   = FIELD_BITS'(line_c);
		tok_c.column = FIELD_BITS'(col_c);
		tok_c.last   = 1'b0;
		if (eos) begin
			// open token, then end of file, then back to the reset state
			a_v          = flush_has;
			b_v          = 1'b1;
			tok_b.line   = FIELD_BITS'(line_q);
			tok_b.column = FIELD_BITS'(col_q);
			mode_d  = MODE_IDLE;
			pos_d   = '0;
			line_d  = POS_BITS'(1);
			col_d   = POS_BITS'(1);
			start_d = '0;
			cand_d  = KW_ALL;
			wl_d    = '0;
		end else begin
			unique case (mode_q)
				MODE_IDENT: begin
					if (ch_letter || ch_numeral) begin
						cont   = 1'b1;
						cand_d = cand_m;
						wl_d   = wl_m;
					end
				end
				MODE_INT: begin
					if (ch_numeral) begin
						cont = 1'b1;
					end else if (ch == CH_DOT) begin
						cont   = 1'b1;
						mode_d = MODE_FRAC;
					end
				end
				MODE_FRAC: cont = ch_numeral;
				MODE_STRING: begin
					cont = 1'b1;
					if (ch == CH_QUOTE) begin
						c_v          = 1'b1;
						tok_c.start  = FIELD_BITS'(start_q);
						tok_c.length = FIELD_BITS'(pos_q - start_q);
						mode_d       = MODE_IDLE;
					end
				end
				MODE_COMMENT: cont = ch != CH_NL;
				MODE_OP_EQ, MODE_OP_BANG, MODE_OP_LT, MODE_OP_GT: begin
					if (ch == CH_EQUAL) begin
						cont   = 1'b1;
						c_v    = 1'b1;
						mode_d = MODE_IDLE;
						case (mode_q)
							MODE_OP_EQ:   tok_c.kind = TK_EQ;
							MODE_OP_BANG: tok_c.kind = TK_NE;
							MODE_OP_LT:   tok_c.kind = TK_LE;
							default:      tok_c.kind = TK_GE;
						endcase
					end
				end
				default: cont = 1'b0;
			endcase
			pos_d  = pos_c;
			line_d = line_c;
			col_d  = col_c;
			if (!cont) begin
				// close the open token, then start from idle on this byte
				a_v    = flush_has;
				mode_d = MODE_IDLE;
				if (ch == CH_NL) begin
					b_v        = 1'b1;
					tok_b.kind = TK_NEWLINE;
				end else if (ch == CH_HASH) begin
					mode_d = MODE_COMMENT;
				end else if (ch_letter) begin
					start_d = pos_q;
					cand_d  = cand_i;
					wl_d    = WL_BITS'(1);
					mode_d  = MODE_IDENT;
				end else if (ch_numeral) begin
					start_d = pos_q;
					mode_d  = MODE_INT;
				end else if (ch == CH_QUOTE) begin
					start_d = pos_c;
					mode_d  = MODE_STRING;
				end else begin
					b_v = 1'b1;
					case (ch)
						CH_PLUS:   tok_b.kind = TK_PLUS;
						CH_MINUS:  tok_b.kind = TK_MINUS;
						CH_STAR:   tok_b.kind = TK_STAR;
						CH_SLASH:  tok_b.kind = TK_SLASH;
						CH_LPAREN: tok_b.kind = TK_LPAREN;
						CH_RPAREN: tok_b.kind = TK_RPAREN;
						CH_COLON:  tok_b.kind = TK_COLON;
						CH_COMMA:  tok_b.kind = TK_COMMA;
						CH_SEMI:   tok_b.kind = TK_SEMI;
						CH_EQUAL: begin
							b_v    = 1'b0;
							mode_d = MODE_OP_EQ;
						end
						CH_BANG: begin
							b_v    = 1'b0;
							mode_d = MODE_OP_BANG;
						end
						CH_LESS: begin
							b_v    = 1'b0;
							mode_d = MODE_OP_LT;
						end
						CH_MORE: begin
							b_v    = 1'b0;
							mode_d = MODE_OP_GT;
						end
						default: b_v = 1'b0;
					endcase
				end
			end
		end
	end

	// pack: flushed or closing token first, idle-step token second
	always_comb begin
		pair.count  = 2'({1'b0, a_v} + {1'b0, b_v} + {1'b0, c_v});
		pair.second = tok_b;
		if (a_v) begin
			pair.first = flush_tok;
		end else if (c_v) begin
			pair.first = tok_c;
		end else begin
			pair.first = tok_b;
		end
		pair.first.last = pair.count == 2'd1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_IDLE;
			pos_q   <= '0;
			line_q  <= POS_BITS'(1);
			col_q   <= POS_BITS'(1);
			start_q <= '0;
			cand_q  <= KW_ALL;
			wl_q    <= '0;
		end else if (step) begin
			mode_q  <= mode_d;
			pos_q   <= pos_d;
			line_q  <= line_d;
			col_q   <= col_d;
			start_q <= start_d;
			cand_q  <= cand_d;
			wl_q    <= wl_d;
		end
	end

endmodule

FILE: design/stt_out_queue.sv
// small token queue, two writes and one read per cycle
`timescale 1ns / 1ps

module stt_out_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_en,
	input  stt_pkg::token_pair_t pair,
	output logic                 room,
	output logic                 head_valid,
	input  logic                 head_ready,
	output stt_pkg::token_t      head
);
	import stt_pkg::*;

	token_t                entry_q [Q_DEPTH];
	logic [Q_PTR_BITS-1:0] wr_ptr_q, rd_ptr_q;
	logic [Q_CNT_BITS-1:0] count_q;
	logic [Q_CNT_BITS-1:0] n_wr;
	logic                  pop;

	assign n_wr       = wr_en ? Q_CNT_BITS'(pair.count) : '0;
	assign pop        = head_valid && head_ready;
	assign head_valid = count_q != '0;
	assign head       = entry_q[rd_ptr_q];
	assign room       = count_q <= Q_CNT_BITS'(Q_DEPTH - 2);

	always_ff @(posedge clk) begin
		if (wr_en && pair.count != 2'd0) begin
			entry_q[wr_ptr_q] <= pair.first;
		end
		if (wr_en && pair.count == 2'd2) begin
			entry_q[wr_ptr_q + Q_PTR_BITS'(1)] <= pair.second;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + Q_PTR_BITS'(n_wr);
			rd_ptr_q <= rd_ptr_q + Q_PTR_BITS'(pop);
			count_q  <= count_q + n_wr - Q_CNT_BITS'(pop);
		end
	end

endmodule

FILE: design/source_text_tokenizer_unit.sv
// top level of the streaming source text tokenizer
`timescale 1ns / 1ps

// channel  | direction | payload
// ---------+-----------+-----------------------------------------------------
// s_axis   | in        | tdata: ch; tuser: end_of_source
// m_axis   | out       | tuser: token_kind; tdata: text_start, text_length,
//          |           | line_number, column_number; tlast: last
//
// one byte per cycle while the queue has room: a transfer lands in the input
// register, the scanner steps on it once the queue has room and writes its
// tokens into a four-entry queue; a byte gives at most two tokens, and the
// one read port of the queue gives one token per cycle while m_axis_tready is high
// reset clears the scanner to idle, counters to position 0, line 1, column 1
// the input register holds while the queue has fewer than two free entries

module source_text_tokenizer_unit (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [7:0]   s_axis_tdata,   // ch
	input  logic         s_axis_tuser,   // end_of_source
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [95:0]  m_axis_tdata,   // text_start, text_length, line_number, column_number
	output logic [4:0]   m_axis_tuser,   // token_kind
	output logic         m_axis_tlast    // last token of one input transfer
);
	import stt_pkg::*;

	// input register
	logic        valid_s1;
	char_t       ch_s1;
	logic        eos_s1;

	logic        room;
	logic        step;
	token_pair_t pair;
	token_t      head;

	// the scanner steps once the queue can take two tokens
	assign step          = valid_s1 && room;
	assign s_axis_tready = !valid_s1 || room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tvalid && s_axis_tready) begin
			valid_s1 <= 1'b1;
		end else if (step) begin
			valid_s1 <= 1'b0;
		end
	end

	// payload needs no reset
	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			ch_s1  <= s_axis_tdata;
			eos_s1 <= s_axis_tuser;
		end
	end

	stt_scan u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.ch     (ch_s1),
		.eos    (eos_s1),
		.pair   (pair)
	);

	// the queue entries act as the result register
	stt_out_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr_en      (step),
		.pair       (pair),
		.room       (room),
		.head_valid (m_axis_tvalid),
		.head_ready (m_axis_tready),
		.head       (head)
	);

	assign m_axis_tuser = head.kind;
	assign m_axis_tdata = {head.column, head.line, head.length, head.start};
	assign m_axis_tlast = head.last;

endmodule

FILE: design/stt_checker.sv
// port checker for the tokenizer, bound to the top level
`timescale 1ns / 1ps

module stt_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic [7:0]  s_axis_tdata,
	input logic        s_axis_tuser,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [95:0] m_axis_tdata,
	input logic [4:0]  m_axis_tuser,
	input logic        m_axis_tlast
);
	import stt_pkg::*;

	logic textless;
	assign textless = m_axis_tuser != TK_INT && m_axis_tuser != TK_FLOAT
		&& m_axis_tuser != TK_STRING && m_axis_tuser != TK_IDENT;

	// a stalled byte transfer holds
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && !s_axis_tready |=> s_axis_tvalid
		&& $stable(s_axis_tdata) && $stable(s_axis_tuser))
		else $error("stalled byte transfer changed");

	// a stalled token holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid
		&& $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))
		else $error("stalled token changed");

	// end of file always closes the tokens of its transfer
	a_eof_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser == TK_EOF |-> m_axis_tlast)
		else $error("eof token without tlast");

	// tokens without text carry no start and no length
	a_no_text: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && textless |-> m_axis_tdata[47:0] == 48'd0)
		else $error("textless token carries text fields");

	// line and column count from one
	a_line_col: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[71:48] != 24'd0 && m_axis_tdata[95:72] != 24'd0)
		else $error("line or column is zero");

endmodule

bind source_text_tokenizer_unit stt_checker u_stt_checker (.*);
